// File: rtl/wsar_pkg.sv
`timescale 1ns / 1ps

package wsar_pkg;

    localparam logic [1:0]  REQ_TICK     = 2'd0;
    localparam logic [1:0]  REQ_DISMISS  = 2'd1;
    localparam logic [1:0]  REQ_TEST     = 2'd2;

    localparam logic [2:0]  CFG_ALARM_ENABLE = 3'd0;
    localparam logic [2:0]  CFG_DAY_MASK     = 3'd1;
    localparam logic [2:0]  CFG_RING_MINUTE  = 3'd2;
    localparam logic [2:0]  CFG_HOLD_MINUTES = 3'd3;
    localparam logic [2:0]  CFG_RAMP_MINUTES = 3'd4;

    localparam logic [13:0] WEEK_MIN     = 14'd10080;
    localparam logic [10:0] DAY_MIN      = 11'd1440;
    localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
    localparam logic [19:0] WEEK_S       = 20'd604800;
    localparam logic [31:0] TEST_RAMP_MS = 32'd60000;
    localparam logic [31:0] TEST_END_MS  = 32'd80000;
    localparam logic [12:0] FULL         = 13'd4096;
    localparam logic [7:0]  LVL_MAX      = 8'd255;

    localparam logic [2:0]  DAY_LAST     = 3'd6;
    localparam logic [3:0]  DIV_LAST     = 4'd11;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        time_valid;
        logic [2:0]  weekday;
        logic [10:0] minute_of_day;
        logic [5:0]  second;
        logic [31:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic        active;
        logic [12:0] progress;
        logic [7:0]  level;
    } t_out_word;

    typedef struct packed {
        logic       load;
        logic       prep;
        logic       dis_step;
        logic       test_clear;
        logic       test_div;
        logic       day_clear_dis;
        logic       day_div;
        logic       full;
        logic       div_step;
        logic       sq;
        logic       lvl;
        logic       inactive;
        logic       out_load;
        logic [2:0] day;
    } t_cmd;

    typedef struct packed {
        logic dis_scan;
        logic test_on;
        logic test_ramp;
        logic test_hold;
        logic eval_ok;
        logic day_on;
        logic dis_match;
        logic in_hold;
        logic in_ramp;
    } t_stat;

endpackage

// File: rtl/weekly_sunrise_alarm_ramp.sv
`timescale 1ns / 1ps

// weekly sunrise alarm ramp
// input channel (i_in_valid / o_in_ready / i_in_word): one word per tick,
//   dismiss or test start request, with time of week and millisecond stamp
// output channel (o_out_valid / i_out_ready / o_out_word): one word per input
//   word with active flag, Q1.12 progress and brightness level
// config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   always ready; user must write only while no word is in flight, not enforced
// a word goes through load and prep, then as needed the day scans (up to 7
//   days each for dismiss and alarm check), the radix-2 progress divider and
//   the square and level steps, before its result is registered
// one word at a time: the next word is accepted the cycle after its
//   predecessor's result is registered
// a finished result waits in the output register; a new word is accepted
//   meanwhile, and its result is held in the datapath while the controller
//   waits until the output register frees up
// reset: config returns to disabled, 07:00 ring, 10 min hold, 30 min ramp;
//   dismissal and test sunrise are cleared
module weekly_sunrise_alarm_ramp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  wsar_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output wsar_pkg::t_out_word o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [10:0]         i_cfg_data
);
    import wsar_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    wsar_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    wsar_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_word  (o_out_word)
    );

    assign o_cfg_ready = 1'b1;

endmodule

// File: rtl/wsar_ctrl.sv
`timescale 1ns / 1ps

module wsar_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  wsar_pkg::t_stat i_stat,
    output wsar_pkg::t_cmd  o_cmd
);
    import wsar_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_DIS,
        S_TEST,
        S_CHECK,
        S_SCAN,
        S_DIV,
        S_SQ,
        S_LVL,
        S_FIN
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_day, n_day;
    logic [3:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    t_cmd       w_cmd;

    always_comb begin
        n_state     = r_state;
        n_day       = r_day;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        w_cmd       = '0;
        w_cmd.day   = r_day;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                w_cmd.prep = 1'b1;
                n_day      = 3'd0;
                n_state    = i_stat.dis_scan ? S_DIS : S_TEST;
            end
            S_DIS: begin
                w_cmd.dis_step = 1'b1;
                if (r_day == DAY_LAST) begin
                    n_state = S_TEST;
                end else begin
                    n_day = r_day + 3'd1;
                end
            end
            S_TEST: begin
                if (!i_stat.test_on) begin
                    n_state = S_CHECK;
                end else if (i_stat.test_ramp) begin
                    w_cmd.test_div = 1'b1;
                    n_cnt          = 4'd0;
                    n_state        = S_DIV;
                end else if (i_stat.test_hold) begin
                    w_cmd.full = 1'b1;
                    n_state    = S_SQ;
                end else begin
                    w_cmd.test_clear = 1'b1;
                    n_state          = S_CHECK;
                end
            end
            S_CHECK: begin
                n_day = 3'd0;
                if (i_stat.eval_ok) begin
                    n_state = S_SCAN;
                end else begin
                    w_cmd.inactive = 1'b1;
                    n_state        = S_FIN;
                end
            end
            S_SCAN: begin
                if (i_stat.day_on && !i_stat.dis_match && i_stat.in_hold) begin
                    w_cmd.full = 1'b1;
                    n_state    = S_SQ;
                end else if (i_stat.day_on && !i_stat.dis_match && i_stat.in_ramp) begin
                    w_cmd.day_div = 1'b1;
                    n_cnt         = 4'd0;
                    n_state       = S_DIV;
                end else begin
                    // dismissed ring outside its window is forgotten
                    if (i_stat.day_on && i_stat.dis_match
                            && !i_stat.in_hold && !i_stat.in_ramp) begin
                        w_cmd.day_clear_dis = 1'b1;
                    end
                    if (r_day == DAY_LAST) begin
                        w_cmd.inactive = 1'b1;
                        n_state        = S_FIN;
                    end else begin
                        n_day = r_day + 3'd1;
                    end
                end
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_SQ;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            S_SQ: begin
                w_cmd.sq = 1'b1;
                n_state  = S_LVL;
            end
            S_LVL: begin
                w_cmd.lvl = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_day       <= 3'd0;
            r_cnt       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_day       <= n_day;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/wsar_dp.sv
`timescale 1ns / 1ps

module wsar_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [2:0]         i_cfg_index,
    input  logic [10:0]        i_cfg_data,
    input  wsar_pkg::t_in_word i_in_word,
    input  wsar_pkg::t_cmd     i_cmd,
    output wsar_pkg::t_stat    o_stat,
    output wsar_pkg::t_out_word o_out_word
);
    import wsar_pkg::*;

    // configuration
    logic        r_alarm_enable;
    logic [6:0]  r_day_mask;
    logic [10:0] r_ring_minute;
    logic [10:0] r_hold_minutes;
    logic [10:0] r_ramp_minutes;

    // alarm state
    logic        r_dis_valid;
    logic [13:0] r_dis_ring;
    logic        r_test_run;
    logic [31:0] r_test_start;

    // per word datapath
    t_in_word    r_in;
    logic [19:0] r_now_s;
    logic [13:0] r_now_m;
    logic [17:0] r_rem;
    logic [16:0] r_dvs;
    logic [12:0] r_prog;
    logic [25:0] r_sq;
    logic [7:0]  r_lvl;
    logic        r_act;
    t_out_word   r_out;

    logic [13:0] w_now_m_raw, w_now_m;
    logic [19:0] w_now_s_raw, w_now_s;
    logic [16:0] w_hold_s, w_ramp_s, w_ramp_div;
    logic [13:0] w_ring, w_ring_m, w_since;
    logic [19:0] w_ring_x60, w_ring_s, w_s, w_b;
    logic        w_in_hold, w_in_ramp, w_dis_hit;
    logic [31:0] w_e;
    logic [17:0] w_trial;
    logic        w_take;
    logic [33:0] w_prod;
    logic [9:0]  w_lvl_sum;

    always_comb begin
        w_now_m_raw = 14'(r_in.weekday) * 14'(DAY_MIN) + 14'(r_in.minute_of_day);
        w_now_m     = (w_now_m_raw >= WEEK_MIN) ? w_now_m_raw - WEEK_MIN : w_now_m_raw;
        w_now_s_raw = 20'(w_now_m_raw) * 20'(SEC_PER_MIN) + 20'(r_in.second);
        w_now_s     = (w_now_s_raw >= WEEK_S) ? w_now_s_raw - WEEK_S : w_now_s_raw;

        w_hold_s   = 17'(r_hold_minutes) * 17'(SEC_PER_MIN);
        w_ramp_s   = 17'(r_ramp_minutes) * 17'(SEC_PER_MIN);
        w_ramp_div = (r_ramp_minutes == 11'd0) ? 17'(SEC_PER_MIN) : w_ramp_s;

        w_ring     = 14'(i_cmd.day) * 14'(DAY_MIN) + 14'(r_ring_minute);
        w_ring_x60 = 20'(w_ring) * 20'(SEC_PER_MIN);
        w_ring_s   = (w_ring_x60 >= WEEK_S) ? w_ring_x60 - WEEK_S : w_ring_x60;
        // wraps inside 20 bits, the true distance always fits
        w_s        = (r_now_s >= w_ring_s) ? r_now_s - w_ring_s
                                           : r_now_s + WEEK_S - w_ring_s;
        w_b        = WEEK_S - w_s;
        w_in_hold  = w_s < {3'b0, w_hold_s};
        w_in_ramp  = w_b <= {3'b0, w_ramp_s};

        w_ring_m   = (w_ring >= WEEK_MIN) ? w_ring - WEEK_MIN : w_ring;
        w_since    = (r_now_m >= w_ring_m) ? r_now_m - w_ring_m
                                           : r_now_m + WEEK_MIN - w_ring_m;
        w_dis_hit  = (w_since < 14'(r_hold_minutes))
                  || ((WEEK_MIN - w_since) <= 14'(r_ramp_minutes));

        w_e        = r_in.now_ms - r_test_start;

        w_trial    = {r_rem[16:0], 1'b0};
        w_take     = w_trial >= {1'b0, r_dvs};

        // times 254 as shift and subtract
        w_prod     = {r_sq, 8'b0} - {7'b0, r_sq, 1'b0};
        w_lvl_sum  = 10'd1 + w_prod[33:24];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_enable <= 1'b0;
            r_day_mask     <= 7'd0;
            r_ring_minute  <= 11'd420;
            r_hold_minutes <= 11'd10;
            r_ramp_minutes <= 11'd30;
            r_dis_valid    <= 1'b0;
            r_dis_ring     <= 14'd0;
            r_test_run     <= 1'b0;
            r_test_start   <= 32'd0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ALARM_ENABLE: r_alarm_enable <= i_cfg_data[0];
                    CFG_DAY_MASK:     r_day_mask     <= i_cfg_data[6:0];
                    CFG_RING_MINUTE:  r_ring_minute  <= i_cfg_data;
                    CFG_HOLD_MINUTES: r_hold_minutes <= i_cfg_data;
                    CFG_RAMP_MINUTES: r_ramp_minutes <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.prep) begin
                if (r_in.req_type == REQ_DISMISS) begin
                    r_test_run <= 1'b0;
                end else if (r_in.req_type == REQ_TEST) begin
                    r_test_run   <= 1'b1;
                    r_test_start <= r_in.now_ms;
                end
            end
            if (i_cmd.test_clear) begin
                r_test_run <= 1'b0;
            end
            if (i_cmd.dis_step && w_dis_hit) begin
                r_dis_ring  <= w_ring;
                r_dis_valid <= 1'b1;
            end
            if (i_cmd.day_clear_dis) begin
                r_dis_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_word;
        end
        if (i_cmd.prep) begin
            r_now_s <= w_now_s;
            r_now_m <= w_now_m;
        end
        if (i_cmd.test_div) begin
            r_rem  <= 18'(w_e[15:0]);
            r_dvs  <= 17'(TEST_RAMP_MS);
            r_prog <= 13'd0;
        end
        if (i_cmd.day_div) begin
            r_rem  <= 18'(w_ramp_div - w_b[16:0]);
            r_dvs  <= w_ramp_div;
            r_prog <= 13'd0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= w_take ? w_trial - {1'b0, r_dvs} : w_trial;
            r_prog <= {r_prog[11:0], w_take};
        end
        if (i_cmd.full) begin
            r_prog <= FULL;
        end
        if (i_cmd.sq) begin
            r_sq <= 26'(r_prog) * 26'(r_prog);
        end
        if (i_cmd.lvl) begin
            r_lvl <= (w_lvl_sum > 10'(LVL_MAX)) ? LVL_MAX : w_lvl_sum[7:0];
            r_act <= 1'b1;
        end
        if (i_cmd.inactive) begin
            r_act  <= 1'b0;
            r_prog <= 13'd0;
            r_lvl  <= 8'd0;
        end
        if (i_cmd.out_load) begin
            r_out.active   <= r_act;
            r_out.progress <= r_prog;
            r_out.level    <= r_lvl;
        end
    end

    always_comb begin
        o_stat.dis_scan  = (r_in.req_type == REQ_DISMISS) && r_in.time_valid;
        o_stat.test_on   = r_test_run;
        o_stat.test_ramp = w_e < TEST_RAMP_MS;
        o_stat.test_hold = w_e < TEST_END_MS;
        o_stat.eval_ok   = r_alarm_enable && r_in.time_valid;
        o_stat.day_on    = r_day_mask[i_cmd.day];
        o_stat.dis_match = r_dis_valid && (r_dis_ring == w_ring);
        o_stat.in_hold   = w_in_hold;
        o_stat.in_ramp   = w_in_ramp;
    end

    assign o_out_word = r_out;

endmodule
